@@ hdl/tamf_pkg.sv @@
`default_nettype none
package tamf_pkg;

    localparam logic [6:0]  MAX_SECTORS     = 7'd32;
    localparam logic [13:0] MAX_TRACK_BYTES = 14'd8192;
    localparam logic [5:0]  DATA_WINDOW     = 6'd43;
    localparam logic [13:0] HEADER_SKIP     = 14'd8;
    localparam logic [5:0]  SKIP_COUNT      = 6'd6;
    localparam logic [13:0] TRACK_LEN_RST   = 14'd6250;

    localparam logic [7:0] MARK_SYNC  = 8'hA1;
    localparam logic [7:0] MARK_ID    = 8'hFE;
    localparam logic [7:0] MARK_DATA  = 8'hFB;
    localparam logic [7:0] MARK_DDATA = 8'hF8;

    typedef enum logic [1:0] {
        EV_HEADER    = 2'd0,
        EV_DATA      = 2'd1,
        EV_MISSING   = 2'd2,
        EV_TRACK_END = 2'd3
    } t_event;

    typedef struct packed {
        t_event      event_res;
        logic [5:0]  sector_index;
        logic [12:0] byte_offset;
        logic [6:0]  sector_count;
        logic        overflow;
        logic        last;
    } t_result;

    // up to two results per byte, res0 first
    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage
`default_nettype wire

@@ hdl/tamf_core.sv @@
`default_nettype none
module tamf_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_byte,
    input  wire logic [13:0]   i_track_length,
    output tamf_pkg::t_push    o_push
);
    import tamf_pkg::*;

    typedef enum logic [1:0] {
        PH_SEEK = 2'd0,
        PH_SKIP = 2'd1,
        PH_DATA = 2'd2,
        PH_IDLE = 2'd3
    } t_phase;

    logic [12:0] r_pos,      n_pos;
    logic [7:0]  r_prev,     n_prev;
    logic        r_usable,   n_usable;
    t_phase      r_phase,    n_phase;
    logic [5:0]  r_count,    n_count;
    logic [6:0]  r_sectors,  n_sectors;
    logic        r_overflow, n_overflow;

    logic [13:0] len;
    logic        final_byte;
    logic        pair;
    t_phase      ph;
    logic        prim_v;
    t_event      prim_ev;
    logic [5:0]  prim_idx;
    logic [12:0] prim_off;
    logic        fmiss;
    logic [5:0]  idx_dec;
    logic [6:0]  cnt_e;
    logic        ovf_e;
    logic [1:0]  num;
    t_result     res_prim, res_miss, res_end;
    t_push       push;

    always_comb begin
        len = i_track_length;
        if (len == 14'd0) begin
            len = 14'd1;
        end
        if (len > MAX_TRACK_BYTES) begin
            len = MAX_TRACK_BYTES;
        end
    end

    assign final_byte = ({1'b0, r_pos} + 14'd1) >= len;
    assign idx_dec    = r_sectors[5:0] - 6'd1;

    always_comb begin
        n_pos      = r_pos;
        n_prev     = i_byte;
        n_usable   = r_usable;
        n_phase    = r_phase;
        n_count    = r_count;
        n_sectors  = r_sectors;
        n_overflow = r_overflow;
        prim_v     = 1'b0;
        prim_ev    = EV_HEADER;
        prim_idx   = r_sectors[5:0];
        prim_off   = r_pos + 13'd1;

        ph = r_phase;
        // short track: never searched
        if (r_pos == 13'd0 && r_phase == PH_SEEK && len <= HEADER_SKIP) begin
            ph = PH_IDLE;
        end
        n_phase = ph;
        pair = r_usable && (r_prev == MARK_SYNC) && !final_byte;

        case (ph)
            PH_SEEK: begin
                if (pair && i_byte == MARK_ID) begin
                    if (r_sectors >= MAX_SECTORS) begin
                        n_overflow = 1'b1;
                        n_phase    = PH_IDLE;
                    end else begin
                        prim_v    = 1'b1;
                        prim_ev   = EV_HEADER;
                        n_sectors = r_sectors + 7'd1;
                        n_phase   = PH_SKIP;
                        n_count   = SKIP_COUNT;
                    end
                    n_usable = 1'b0;
                end else begin
                    n_usable = 1'b1;
                end
            end
            PH_SKIP: begin
                n_count = (r_count != 6'd0) ? r_count - 6'd1 : r_count;
                if (n_count == 6'd0) begin
                    n_phase = PH_DATA;
                    n_count = DATA_WINDOW;
                end
                n_usable = 1'b0;
            end
            PH_DATA: begin
                if (pair && (i_byte == MARK_DATA || i_byte == MARK_DDATA)) begin
                    prim_v   = 1'b1;
                    prim_ev  = EV_DATA;
                    prim_idx = idx_dec;
                    // resume from the A1 of the data mark
                    if (({1'b0, r_pos} + HEADER_SKIP - 14'd1) >= len) begin
                        n_phase  = PH_IDLE;
                        n_usable = 1'b0;
                    end else begin
                        n_phase  = PH_SEEK;
                        n_usable = 1'b1;
                    end
                end else if (r_count == 6'd0) begin
                    prim_v   = 1'b1;
                    prim_ev  = EV_MISSING;
                    prim_idx = idx_dec;
                    prim_off = 13'd0;
                    if (({1'b0, r_pos} + HEADER_SKIP) >= len) begin
                        n_phase  = PH_IDLE;
                        n_usable = 1'b0;
                    end else begin
                        n_phase  = PH_SEEK;
                        n_usable = 1'b1;
                    end
                end else begin
                    n_count  = r_count - 6'd1;
                    n_usable = 1'b1;
                end
            end
            default: begin
                n_usable = 1'b0;
            end
        endcase

        fmiss = final_byte && (n_phase == PH_SKIP || n_phase == PH_DATA);
        cnt_e = n_sectors;
        ovf_e = n_overflow;

        if (final_byte) begin
            n_pos      = 13'd0;
            n_usable   = 1'b0;
            n_phase    = PH_SEEK;
            n_count    = 6'd0;
            n_sectors  = 7'd0;
            n_overflow = 1'b0;
        end else begin
            n_pos = r_pos + 13'd1;
        end
    end

    always_comb begin
        res_prim = '{event_res: prim_ev, sector_index: prim_idx, byte_offset: prim_off,
                     sector_count: cnt_e, overflow: ovf_e, last: 1'b0};
        res_miss = '{event_res: EV_MISSING, sector_index: idx_dec, byte_offset: 13'd0,
                     sector_count: cnt_e, overflow: ovf_e, last: 1'b0};
        res_end  = '{event_res: EV_TRACK_END, sector_index: 6'd0, byte_offset: 13'd0,
                     sector_count: cnt_e, overflow: ovf_e, last: 1'b0};

        num = {1'b0, prim_v} + {1'b0, fmiss} + {1'b0, final_byte};

        push.res0 = prim_v ? res_prim : (fmiss ? res_miss : res_end);
        push.res1 = res_end;
        if (num == 2'd2) begin
            push.res1.last = 1'b1;
        end else begin
            push.res0.last = 1'b1;
        end
        push.num = i_accept ? num : 2'd0;
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= 13'd0;
            r_prev     <= 8'd0;
            r_usable   <= 1'b0;
            r_phase    <= PH_SEEK;
            r_count    <= 6'd0;
            r_sectors  <= 7'd0;
            r_overflow <= 1'b0;
        end else if (i_accept) begin
            r_pos      <= n_pos;
            r_prev     <= n_prev;
            r_usable   <= n_usable;
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_sectors  <= n_sectors;
            r_overflow <= n_overflow;
        end
    end

endmodule
`default_nettype wire

@@ hdl/tamf_out_fifo.sv @@
`default_nettype none
module tamf_out_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tamf_pkg::t_push i_push,
    output logic               o_room,
    output logic               o_valid,
    input  wire logic          i_ready,
    output tamf_pkg::t_result  o_head
);
    import tamf_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    t_result            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [PTR_W:0]     r_count,  n_count;
    logic               pop;

    assign pop     = (r_count != '0) && i_ready;
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    // room for the worst case of two words from one byte
    assign o_room  = r_count <= (PTR_W+1)'(DEPTH - 2);

    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(i_push.num);
        n_rd_ptr = r_rd_ptr + PTR_W'(pop);
        n_count  = r_count + (PTR_W+1)'(i_push.num) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[r_wr_ptr + PTR_W'(1)] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

@@ hdl/track_address_mark_finder.sv @@
`default_nettype none
// Scans the raw bytes of a floppy track, one byte per input word, for ID marks (A1 FE) and
// the data marks (A1 FB / A1 F8) that follow them within 43 bytes, and emits header, data,
// missing-data and track-end events with offsets, sector count and overflow flag. The
// position wraps at track_length (0 acts as 1, above 8192 as 8192); write it only while idle.
// The search state updates in the accept cycle and a byte's result words (none, one or two)
// go into a four-word output queue, so a byte is taken every cycle while the queue has room
// for two words; output stalls back up into s_axis_tready.
module track_address_mark_finder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [13:0] i_cfg_data,      // track_length
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,  // track_byte
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [5:0] sector_index, [18:6] byte_offset, [25:19] sector_count, [26] overflow, rest 0
    output logic [31:0]      o_m_axis_tdata,
    output logic [1:0]       o_m_axis_tuser,  // event_res
    output logic             o_m_axis_tlast   // last word of a byte
);
    import tamf_pkg::*;

    logic [13:0] r_track_length;
    logic        accept;
    logic        room;
    t_push       push;
    t_result     head;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = room;
    assign accept          = i_s_axis_tvalid && room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_length <= TRACK_LEN_RST;
        end else if (i_cfg_valid) begin
            r_track_length <= i_cfg_data;
        end
    end

    tamf_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_byte         (i_s_axis_tdata),
        .i_track_length (r_track_length),
        .o_push         (push)
    );

    tamf_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_head  (head)
    );

    assign o_m_axis_tdata = {5'd0, head.overflow, head.sector_count, head.byte_offset,
                             head.sector_index};
    assign o_m_axis_tuser = head.event_res;
    assign o_m_axis_tlast = head.last;

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import tamf_pkg::*;

    localparam int ITEM_TARGET  = 1850;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [1:0] {
        SEEK_HDR,
        SKIP_HDR,
        DATA_WIN,
        IDLE_TRK
    } t_scan_phase;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [13:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = '0;   // track_byte
    logic        m_tready  = 1'b1;
    wire         cfg_ready;
    wire         s_tready;
    wire         m_tvalid;
    wire  [31:0] m_tdata;          // sector_index, byte_offset, sector_count, overflow
    wire  [1:0]  m_tuser;          // event_res
    wire         m_tlast;

    // scanner state as the block should hold it
    logic [13:0] track_len_cfg = TRACK_LEN_RST;
    logic [12:0] scan_pos      = '0;
    logic [7:0]  prev_byte     = '0;
    logic        prev_usable   = 1'b0;
    t_scan_phase scan_phase    = SEEK_HDR;
    logic [5:0]  scan_count    = '0;
    logic [6:0]  sectors_seen  = '0;
    logic        sector_ovf    = 1'b0;

    t_result     mark_events[$];   // expected result words, oldest first
    t_result     byte_events[$];   // words raised by the byte being predicted
    logic [7:0]  track_img[$];
    int          err_cnt        = 0;
    int          bytes_sent     = 0;
    int          src_gap_max    = 0;
    int          sink_stall_max = 0;
    int          quiet_cycles   = 0;

    track_address_mark_finder u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic void note_event(t_event ev, logic [5:0] idx, logic [12:0] offset);
        t_result r;
        r.event_res    = ev;
        r.sector_index = idx;
        r.byte_offset  = offset;
        r.sector_count = sectors_seen;
        r.overflow     = sector_ovf;
        r.last         = 1'b0;
        byte_events.push_back(r);
    endfunction

    // after a data mark or a closed window; too close to the track end means idle
    function automatic void resume_search(int unsigned start, int unsigned len);
        if (start + 8 >= len) begin
            scan_phase  = IDLE_TRK;
            prev_usable = 1'b0;
        end else begin
            scan_phase  = SEEK_HDR;
            prev_usable = 1'b1;
        end
    endfunction

    function automatic void predict_byte(logic [7:0] b);
        int unsigned len;
        int unsigned pos;
        bit          at_end;
        bit          pair;
        t_result     r;
        len = track_len_cfg;
        if (len == 0) len = 1;
        if (len > MAX_TRACK_BYTES) len = MAX_TRACK_BYTES;
        pos    = scan_pos;
        at_end = (pos + 1 >= len);
        if (pos == 0 && scan_phase == SEEK_HDR && len <= HEADER_SKIP) scan_phase = IDLE_TRK;
        // a pair ending on the last byte would put its field past the track
        pair = prev_usable && prev_byte == MARK_SYNC && !at_end;
        case (scan_phase)
            SEEK_HDR: begin
                if (pair && b == MARK_ID) begin
                    if (sectors_seen >= MAX_SECTORS) begin
                        sector_ovf = 1'b1;
                        scan_phase = IDLE_TRK;
                    end else begin
                        sectors_seen = sectors_seen + 7'd1;
                        note_event(EV_HEADER, 6'(sectors_seen - 7'd1), 13'(pos + 1));
                        scan_phase = SKIP_HDR;
                        scan_count = SKIP_COUNT;
                    end
                    prev_usable = 1'b0;
                end else begin
                    prev_usable = 1'b1;
                end
            end
            SKIP_HDR: begin
                if (scan_count != 0) scan_count = scan_count - 6'd1;
                if (scan_count == 0) begin
                    scan_phase = DATA_WIN;
                    scan_count = DATA_WINDOW;
                end
                prev_usable = 1'b0;
            end
            DATA_WIN: begin
                if (pair && (b == MARK_DATA || b == MARK_DDATA)) begin
                    note_event(EV_DATA, 6'(sectors_seen - 7'd1), 13'(pos + 1));
                    resume_search(pos - 1, len);
                end else if (scan_count == 0) begin
                    note_event(EV_MISSING, 6'(sectors_seen - 7'd1), '0);
                    resume_search(pos, len);
                end else begin
                    scan_count  = scan_count - 6'd1;
                    prev_usable = 1'b1;
                end
            end
            default: prev_usable = 1'b0;
        endcase
        prev_byte = b;
        if (at_end) begin
            if (scan_phase == SKIP_HDR || scan_phase == DATA_WIN)
                note_event(EV_MISSING, 6'(sectors_seen - 7'd1), '0);
            note_event(EV_TRACK_END, '0, '0);
            scan_pos     = '0;
            prev_usable  = 1'b0;
            scan_phase   = SEEK_HDR;
            scan_count   = '0;
            sectors_seen = '0;
            sector_ovf   = 1'b0;
        end else begin
            scan_pos = 13'(pos + 1);
        end
        while (byte_events.size() != 0) begin
            r      = byte_events.pop_front();
            r.last = (byte_events.size() == 0);
            mark_events.push_back(r);
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    function automatic logic [7:0] noise_byte();
        return ($urandom_range(0, 15) == 0) ? MARK_SYNC : 8'($urandom);
    endfunction

    // sectors laid out as ID mark, header, gap, data mark, data; dense packs them tight
    task automatic build_track(input int unsigned n, input bit dense);
        int unsigned k;
        track_img.delete();
        while (track_img.size() < n) begin
            if (dense || $urandom_range(0, 2) != 0) begin
                track_img.push_back(MARK_SYNC);
                track_img.push_back((dense || $urandom_range(0, 7) != 0) ? MARK_ID : 8'($urandom));
                k = (dense || $urandom_range(0, 5) != 0) ? 6 : $urandom_range(2, 6);
                repeat (k) track_img.push_back(8'($urandom));
                if (!dense) begin
                    // lean toward the edge of the data window
                    k = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 44)
                                                    : $urandom_range(0, 50);
                    repeat (k) track_img.push_back(noise_byte());
                end
                track_img.push_back(MARK_SYNC);
                case ($urandom_range(0, dense ? 1 : 3))
                    0: track_img.push_back(MARK_DATA);
                    1: track_img.push_back(MARK_DDATA);
                    2: track_img.push_back(MARK_SYNC);
                    default: track_img.push_back(8'($urandom));
                endcase
                if (!dense) repeat ($urandom_range(0, 30)) track_img.push_back(noise_byte());
            end else begin
                repeat ($urandom_range(1, 12)) track_img.push_back(noise_byte());
            end
        end
        while (track_img.size() > n) void'(track_img.pop_back());
        if (!dense && n >= 2 && $urandom_range(0, 3) == 0) begin
            track_img[n - 2] = MARK_SYNC;
            track_img[n - 1] = ($urandom_range(0, 1) != 0) ? MARK_ID : MARK_DATA;
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (src_gap_max == 0) ? 0 : $urandom_range(0, src_gap_max);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        predict_byte(b);
        bytes_sent++;
    endtask

    task automatic send_track(input int unsigned n);
        for (int i = 0; i < n && i < track_img.size(); i++) send_byte(track_img[i]);
    endtask

    // a byte may raise nothing, so keep draining past the last expected word
    task automatic settle();
        s_tvalid <= 1'b0;
        while (mark_events.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_track_length(input logic [13:0] len);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        track_len_cfg = len;
    endtask

    task automatic pick_pacing();
        src_gap_max    = ($urandom_range(0, 2) == 0) ? 0 : 19;
        sink_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
    endtask

    task automatic test_basic_marks();
        logic [7:0] rest_a[13] = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, MARK_SYNC,
                                   MARK_DDATA, 8'hFF, 8'h00, 8'h55, MARK_SYNC, MARK_ID};
        logic [7:0] trk_b[10]  = '{MARK_SYNC, MARK_ID, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01,
                                   8'h80, MARK_SYNC, MARK_DATA};
        src_gap_max    = 0;
        sink_stall_max = 0;
        // header at reset length, then the track shortened under it
        send_byte(8'h00);
        send_byte(MARK_SYNC);
        send_byte(MARK_ID);
        settle();
        write_track_length(14'd16);
        foreach (rest_a[i]) send_byte(rest_a[i]);
        settle();
        // window still open at track end
        sink_stall_max = 19;
        write_track_length(14'd10);
        foreach (trk_b[i]) send_byte(trk_b[i]);
        settle();
    endtask

    task automatic test_length_extremes();
        int unsigned odd_len[7]  = '{0, 1, 8, 9, 16383, 8192, 16};
        int unsigned n_bytes[7]  = '{6, 6, 16, 18, 150, 150, 32};
        bit          dense_of[7] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
        foreach (odd_len[i]) begin
            pick_pacing();
            if (i != 5 && i != 6) settle();
            else begin
                // keep the position running so the shorter length cuts the track
                s_tvalid <= 1'b0;
                while (mark_events.size() != 0) @(posedge clk);
                repeat (DRAIN_CYCLES) @(posedge clk);
            end
            write_track_length(14'(odd_len[i]));
            build_track(n_bytes[i], dense_of[i]);
            send_track(n_bytes[i]);
        end
        settle();
    endtask

    task automatic test_sector_limit();
        // 322: 33rd pair lands on the last byte; 360: overflow
        int unsigned lens[2] = '{322, 360};
        foreach (lens[i]) begin
            pick_pacing();
            settle();
            write_track_length(14'(lens[i]));
            build_track(lens[i], 1'b1);
            send_track(lens[i]);
        end
        settle();
    endtask

    task automatic test_random_tracks();
        int unsigned len;
        int unsigned n;
        while (bytes_sent < ITEM_TARGET) begin
            pick_pacing();
            settle();
            case ($urandom_range(0, 9))
                0: len = $urandom_range(9, 24);
                1: len = $urandom_range(300, 420);
                default: len = $urandom_range(16, 160);
            endcase
            write_track_length(14'(len));
            build_track(len, $urandom_range(0, 7) == 0);
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, len) : len;
            send_track(n);
        end
        settle();
    endtask

    initial begin : result_sink
        int unsigned stall;
        t_result     want;
        forever begin
            stall = (sink_stall_max == 0) ? 0 : $urandom_range(0, sink_stall_max);
            if (stall != 0) begin
                m_tready <= 1'b0;
                do @(posedge clk); while (!m_tvalid);
                repeat (stall - 1) @(posedge clk);
                m_tready <= 1'b1;
            end
            do @(posedge clk); while (!(m_tvalid && m_tready));
            if (mark_events.size() == 0) begin
                $error("unexpected word: event %0d, tdata %h, tlast %b",
                       m_tuser, m_tdata, m_tlast);
                err_cnt++;
            end else begin
                want = mark_events.pop_front();
                check_field("event_res", 32'(want.event_res), 32'(m_tuser));
                check_field("sector_index", 32'(want.sector_index), 32'(m_tdata[5:0]));
                check_field("byte_offset", 32'(want.byte_offset), 32'(m_tdata[18:6]));
                check_field("sector_count", 32'(want.sector_count), 32'(m_tdata[25:19]));
                check_field("overflow", 32'(want.overflow), 32'(m_tdata[26]));
                check_field("tdata padding", 32'd0, 32'(m_tdata[31:27]));
                check_field("last", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_marks();
        test_length_extremes();
        test_sector_limit();
        test_random_tracks();
        settle();
        repeat (20) @(posedge clk);
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
